// File: hdl/acr_pkg.sv
// Shared constants and types for the box pair collision resolver.
package acr_pkg;

    localparam int DEF_COMP_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int DEF_MASS_WIDTH = 16;

    localparam int TIME_W = 16;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_BOTH,
        MODE_BOUNCE_A,
        MODE_BOUNCE_B
    } t_mode;

endpackage

// File: hdl/acr_div.sv
// Pipelined restoring divider with saturation flag, one quotient bit per stage.
module acr_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 17,
    parameter int Q_W   = 16,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic [Q_W:0]     i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_sat,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_rem_nz,
    output logic [PAY_W-1:0] o_pay
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_low [0:Q_W];
    logic [Q_W-1:0]   r_quo [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic             r_sat [0:Q_W];
    logic [PAY_W-1:0] r_pay [0:Q_W];

    logic [CMP_W-1:0] hi_x;
    logic [CMP_W-1:0] den_x;

    assign hi_x  = CMP_W'(i_num[NUM_W-1:Q_W]);
    assign den_x = CMP_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= hi_x[DEN_W-1:0];
            r_low[0] <= i_num[Q_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_sat[0] <= (hi_x >= den_x);
            r_pay[0] <= i_pay;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;
        logic [DEN_W:0] diff;

        assign trial = {r_rem[k-1], r_low[k-1][Q_W-1]};
        assign ge    = (trial >= {1'b0, r_den[k-1]});
        assign diff  = trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_low[k] <= {r_low[k-1][Q_W-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][Q_W-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_sat    = r_sat[Q_W];
    assign o_quo    = r_quo[Q_W];
    assign o_rem_nz = (r_rem[Q_W] != '0);
    assign o_pay    = r_pay[Q_W];

endmodule

// File: hdl/acr_lane.sv
// One axis lane: overlap test, penetration depth and penetration time.
module acr_lane #(
    parameter int COMP_WIDTH = acr_pkg::DEF_COMP_WIDTH,
    parameter int FRAC_BITS  = acr_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic [acr_pkg::TIME_W+1:0]   i_en,
    input  logic signed [COMP_WIDTH-1:0] i_pos_a,
    input  logic signed [COMP_WIDTH-1:0] i_half_a,
    input  logic signed [COMP_WIDTH-1:0] i_vel_a,
    input  logic signed [COMP_WIDTH-1:0] i_pos_b,
    input  logic signed [COMP_WIDTH-1:0] i_half_b,
    input  logic signed [COMP_WIDTH-1:0] i_vel_b,
    output logic                         o_overlap,
    output logic                         o_moving,
    output logic [acr_pkg::TIME_W-1:0]   o_time
);

    localparam int CW   = COMP_WIDTH;
    localparam int TW   = acr_pkg::TIME_W;
    localparam int TN_W = CW + 2 + FRAC_BITS + TW;

    logic signed [CW:0]   amin, amax, bmin, bmax, vr;
    logic signed [CW+1:0] depth;
    logic [CW+1:0]        absd;
    logic [CW:0]          absv;
    logic [TN_W-1:0]      n_num;

    logic [TN_W-1:0] r_num;
    logic [CW:0]     r_den;
    logic [1:0]      r_flags;

    logic            d_sat;
    logic [TW-1:0]   d_quo;
    logic            d_rem_nz;
    logic [1:0]      d_flags;

    always_comb begin
        amin  = i_pos_a - i_half_a;
        amax  = i_pos_a + i_half_a;
        bmin  = i_pos_b - i_half_b;
        bmax  = i_pos_b + i_half_b;
        vr    = i_vel_b - i_vel_a;
        depth = vr[CW] ? (amax - bmin) : (bmax - amin);
        absd  = depth[CW+1] ? (-depth) : depth;
        absv  = vr[CW] ? (-vr) : vr;
        n_num = TN_W'(absd) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num   <= n_num;
            r_den   <= absv;
            r_flags <= {!((amin > bmax) || (bmin > amax)), (vr != '0)};
        end
    end

    acr_div #(
        .NUM_W (TN_W),
        .DEN_W (CW + 1),
        .Q_W   (TW),
        .PAY_W (2)
    ) u_div (
        .i_clk    (i_clk),
        .i_en     (i_en[TW+1:1]),
        .i_num    (r_num),
        .i_den    (r_den),
        .i_pay    (r_flags),
        .o_sat    (d_sat),
        .o_quo    (d_quo),
        .o_rem_nz (d_rem_nz),
        .o_pay    (d_flags)
    );

    assign o_overlap = d_flags[1];
    assign o_moving  = d_flags[0] && (d_rem_nz || !d_rem_nz);
    assign o_time    = d_sat ? {TW{1'b1}} : d_quo;

endmodule

// File: hdl/acr_merge.sv
// Merging stage: combines the lane results into hit, axis and penetration time.
module acr_merge #(
    parameter int ITEM_W = 200
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [2:0]                          i_overlap,
    input  logic [2:0]                          i_moving,
    input  logic [2:0][acr_pkg::TIME_W-1:0]     i_time,
    input  logic [ITEM_W-1:0]                   i_item,
    output logic                                o_hit,
    output logic [1:0]                          o_axis,
    output logic [acr_pkg::TIME_W-1:0]          o_time,
    output logic [ITEM_W-1:0]                   o_item
);

    logic                         n_hit;
    logic [1:0]                   n_axis;
    logic [acr_pkg::TIME_W-1:0]   n_time;
    logic                         found;

    always_comb begin
        n_hit  = &i_overlap;
        n_axis = acr_pkg::AXIS_X;
        n_time = '0;
        found  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (i_moving[i] && (!found || (i_time[i] < n_time))) begin
                n_time = i_time[i];
                n_axis = 2'(i);
                found  = 1'b1;
            end
        end
        if (!n_hit) begin
            n_axis = acr_pkg::AXIS_X;
            n_time = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit  <= n_hit;
            o_axis <= n_axis;
            o_time <= n_time;
            o_item <= i_item;
        end
    end

endmodule

// File: hdl/acr_resp.sv
// Response pipeline: back-off, mass-weighted velocity exchange and re-advance, or reflection of one box.
module acr_resp #(
    parameter int COMP_WIDTH = acr_pkg::DEF_COMP_WIDTH,
    parameter int FRAC_BITS  = acr_pkg::DEF_FRAC_BITS,
    parameter int MASS_WIDTH = acr_pkg::DEF_MASS_WIDTH
) (
    input  logic                         i_clk,
    input  logic [COMP_WIDTH+6:0]        i_en,
    input  logic                         i_hit,
    input  logic [1:0]                   i_axis,
    input  logic [acr_pkg::TIME_W-1:0]   i_time,
    input  logic [3*COMP_WIDTH-1:0]      i_pos_a,
    input  logic [3*COMP_WIDTH-1:0]      i_vel_a,
    input  logic [3*COMP_WIDTH-1:0]      i_pos_b,
    input  logic [3*COMP_WIDTH-1:0]      i_vel_b,
    input  logic [MASS_WIDTH-1:0]        i_mass_a,
    input  logic [MASS_WIDTH-1:0]        i_mass_b,
    output logic                         o_hit,
    output logic [1:0]                   o_hit_axis,
    output logic [acr_pkg::TIME_W-1:0]   o_impact_time,
    output logic [3*COMP_WIDTH-1:0]      o_new_pos_a,
    output logic [3*COMP_WIDTH-1:0]      o_new_vel_a,
    output logic [3*COMP_WIDTH-1:0]      o_new_pos_b,
    output logic [3*COMP_WIDTH-1:0]      o_new_vel_b
);

    localparam int CW    = COMP_WIDTH;
    localparam int MW    = MASS_WIDTH;
    localparam int TW    = acr_pkg::TIME_W;
    localparam int VW    = 3 * CW;
    localparam int PRW   = CW + TW + 1;
    localparam int PW    = CW + 19;
    localparam int MPW   = MW + CW + 1;
    localparam int NW    = MW + CW + 3;
    localparam int QW    = CW + 1;
    localparam int CTX_W = 1 + 2 + TW + 2 + 4 * VW;
    localparam int PAY_W = CTX_W + 4 * PW + 1;
    localparam int O_MD  = 4 * VW;
    localparam int O_TM  = O_MD + 2;
    localparam int O_AX  = O_TM + TW;
    localparam int O_HT  = O_AX + 2;

    function automatic logic [CW-1:0] comp(input logic [VW-1:0] v, input logic [1:0] ax);
        logic [CW-1:0] r;
        unique case (ax)
            acr_pkg::AXIS_Y: r = v[2*CW-1:CW];
            acr_pkg::AXIS_Z: r = v[3*CW-1:2*CW];
            default:         r = v[CW-1:0];
        endcase
        return r;
    endfunction

    function automatic logic [VW-1:0] put(input logic [VW-1:0] v, input logic [1:0] ax,
                                          input logic [CW-1:0] c);
        logic [VW-1:0] r;
        r = v;
        unique case (ax)
            acr_pkg::AXIS_Y: r[2*CW-1:CW]   = c;
            acr_pkg::AXIS_Z: r[3*CW-1:2*CW] = c;
            default:         r[CW-1:0]      = c;
        endcase
        return r;
    endfunction

    function automatic logic [CW-1:0] sat_c(input logic signed [PW+1:0] x);
        logic [PW-CW+2:0] hi_bits;
        logic [CW-1:0]    r;
        hi_bits = x[PW+1:CW-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            r = x[CW-1:0];
        end else begin
            r = x[PW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    // Stage 1: products.
    logic signed [CW-1:0]  s1_a0, s1_b0;
    logic signed [TW:0]    s1_t;
    logic signed [MW:0]    s1_dm, s1_ma, s1_mb;
    acr_pkg::t_mode        s1_mode;

    logic [CTX_W-1:0]      r1_ctx;
    logic signed [PRW-1:0] r1_pta, r1_ptb;
    logic signed [MPW-1:0] r1_na1, r1_na2, r1_nb1, r1_nb2;
    logic [MW:0]           r1_msum;

    always_comb begin
        s1_a0 = comp(i_vel_a, i_axis);
        s1_b0 = comp(i_vel_b, i_axis);
        s1_t  = {1'b0, i_time};
        s1_ma = {1'b0, i_mass_a};
        s1_mb = {1'b0, i_mass_b};
        s1_dm = s1_ma - s1_mb;
        if (!i_hit) begin
            s1_mode = acr_pkg::MODE_PASS;
        end else if ((i_mass_a != '0) && (i_mass_b != '0)) begin
            s1_mode = acr_pkg::MODE_BOTH;
        end else if ((i_mass_a != '0) && (i_mass_b == '0)) begin
            s1_mode = acr_pkg::MODE_BOUNCE_A;
        end else if ((i_mass_a == '0) && (i_mass_b != '0)) begin
            s1_mode = acr_pkg::MODE_BOUNCE_B;
        end else begin
            s1_mode = acr_pkg::MODE_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_ctx  <= {i_hit, i_axis, i_time, s1_mode, i_pos_a, i_vel_a, i_pos_b, i_vel_b};
            r1_pta  <= s1_a0 * s1_t;
            r1_ptb  <= s1_b0 * s1_t;
            r1_na1  <= s1_dm * s1_a0;
            r1_na2  <= s1_mb * s1_b0;
            r1_nb1  <= (-s1_dm) * s1_b0;
            r1_nb2  <= s1_ma * s1_a0;
            r1_msum <= {1'b0, i_mass_a} + {1'b0, i_mass_b};
        end
    end

    // Stage 2: back-off positions and exchange numerators.
    logic [1:0]           s2_ax;
    logic signed [CW-1:0] s2_pa0, s2_pb0;
    logic signed [PRW:0]  s2_dbla, s2_dblb;
    logic signed [MPW:0]  s2_x2a, s2_x2b;
    logic signed [NW-1:0] s2_na, s2_nb;

    logic [CTX_W-1:0]     r2_ctx;
    logic signed [PW-1:0] r2_pa1, r2_pb1, r2_pra, r2_prb;
    logic [NW-1:0]        r2_na_mag, r2_nb_mag;
    logic                 r2_na_neg, r2_nb_neg;
    logic [MW:0]          r2_msum;

    always_comb begin
        s2_ax   = r1_ctx[O_AX+1:O_AX];
        s2_pa0  = comp(r1_ctx[4*VW-1:3*VW], s2_ax);
        s2_pb0  = comp(r1_ctx[2*VW-1:VW], s2_ax);
        s2_dbla = {r1_pta, 1'b0};
        s2_dblb = {r1_ptb, 1'b0};
        s2_x2a  = {r1_na2, 1'b0};
        s2_x2b  = {r1_nb2, 1'b0};
        s2_na   = r1_na1 + s2_x2a;
        s2_nb   = r1_nb1 + s2_x2b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_ctx    <= r1_ctx;
            r2_pa1    <= s2_pa0 - (r1_pta >>> FRAC_BITS);
            r2_pb1    <= s2_pb0 - (r1_ptb >>> FRAC_BITS);
            r2_pra    <= s2_pa0 - (s2_dbla >>> FRAC_BITS);
            r2_prb    <= s2_pb0 - (s2_dblb >>> FRAC_BITS);
            r2_na_mag <= s2_na[NW-1] ? (-s2_na) : s2_na;
            r2_nb_mag <= s2_nb[NW-1] ? (-s2_nb) : s2_nb;
            r2_na_neg <= s2_na[NW-1];
            r2_nb_neg <= s2_nb[NW-1];
            r2_msum   <= r1_msum;
        end
    end

    // Division by the mass sum.
    logic             da_sat, db_sat, da_rnz, db_rnz;
    logic [QW-1:0]    da_quo, db_quo;
    logic [PAY_W-1:0] da_pay;
    logic             db_neg;

    acr_div #(
        .NUM_W (NW),
        .DEN_W (MW + 1),
        .Q_W   (QW),
        .PAY_W (PAY_W)
    ) u_div_a (
        .i_clk    (i_clk),
        .i_en     (i_en[QW+2:2]),
        .i_num    (r2_na_mag),
        .i_den    (r2_msum),
        .i_pay    ({r2_ctx, r2_pa1, r2_pb1, r2_pra, r2_prb, r2_na_neg}),
        .o_sat    (da_sat),
        .o_quo    (da_quo),
        .o_rem_nz (da_rnz),
        .o_pay    (da_pay)
    );

    acr_div #(
        .NUM_W (NW),
        .DEN_W (MW + 1),
        .Q_W   (QW),
        .PAY_W (1)
    ) u_div_b (
        .i_clk    (i_clk),
        .i_en     (i_en[QW+2:2]),
        .i_num    (r2_nb_mag),
        .i_den    (r2_msum),
        .i_pay    (r2_nb_neg),
        .o_sat    (db_sat),
        .o_quo    (db_quo),
        .o_rem_nz (db_rnz),
        .o_pay    (db_neg)
    );

    // Stage 3: floor correction and saturation of the new velocities.
    logic                 s3_na_neg;
    logic [QW:0]          s3_mag_a, s3_mag_b;
    logic signed [QW+1:0] s3_val_a, s3_val_b;
    logic [CW-1:0]        s3_va, s3_vb;

    logic [PAY_W-2:0]     r3_pay;
    logic [CW-1:0]        r3_va, r3_vb;

    always_comb begin
        s3_na_neg = da_pay[0];
        s3_mag_a  = {1'b0, da_quo} + (QW+1)'(s3_na_neg && da_rnz);
        s3_mag_b  = {1'b0, db_quo} + (QW+1)'(db_neg && db_rnz);
        s3_val_a  = s3_na_neg ? -$signed({1'b0, s3_mag_a}) : $signed({1'b0, s3_mag_a});
        s3_val_b  = db_neg ? -$signed({1'b0, s3_mag_b}) : $signed({1'b0, s3_mag_b});
        if (da_sat) begin
            s3_va = s3_na_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            s3_va = sat_c(s3_val_a);
        end
        if (db_sat) begin
            s3_vb = db_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            s3_vb = sat_c(s3_val_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+3]) begin
            r3_pay <= da_pay[PAY_W-1:1];
            r3_va  <= s3_va;
            r3_vb  <= s3_vb;
        end
    end

    // Stage 4: advance products with the new velocities.
    logic signed [TW:0]    s4_t;
    logic [PAY_W-2:0]      r4_pay;
    logic signed [CW-1:0]  r4_va, r4_vb;
    logic signed [PRW-1:0] r4_ptna, r4_ptnb;

    assign s4_t = {1'b0, r3_pay[4*PW+O_AX-1:4*PW+O_TM]};

    always_ff @(posedge i_clk) begin
        if (i_en[QW+4]) begin
            r4_pay  <= r3_pay;
            r4_va   <= r3_va;
            r4_vb   <= r3_vb;
            r4_ptna <= $signed(r3_va) * s4_t;
            r4_ptnb <= $signed(r3_vb) * s4_t;
        end
    end

    // Stage 5: final positions and output register.
    logic [CTX_W-1:0]     s5_ctx;
    logic signed [PW-1:0] s5_pa1, s5_pb1, s5_pra, s5_prb;
    logic [1:0]           s5_ax;
    logic signed [CW-1:0] s5_a0, s5_b0;
    logic [VW-1:0]        s5_pa, s5_va, s5_pb, s5_vb;

    always_comb begin
        s5_ctx = r4_pay[PAY_W-2:4*PW];
        s5_pa1 = r4_pay[4*PW-1:3*PW];
        s5_pb1 = r4_pay[3*PW-1:2*PW];
        s5_pra = r4_pay[2*PW-1:PW];
        s5_prb = r4_pay[PW-1:0];
        s5_ax  = s5_ctx[O_AX+1:O_AX];
        s5_pa  = s5_ctx[4*VW-1:3*VW];
        s5_va  = s5_ctx[3*VW-1:2*VW];
        s5_pb  = s5_ctx[2*VW-1:VW];
        s5_vb  = s5_ctx[VW-1:0];
        s5_a0  = comp(s5_va, s5_ax);
        s5_b0  = comp(s5_vb, s5_ax);
        unique case (acr_pkg::t_mode'(s5_ctx[O_MD+1:O_MD]))
            acr_pkg::MODE_BOTH: begin
                s5_pa = put(s5_pa, s5_ax, sat_c(s5_pa1 + (r4_ptna >>> FRAC_BITS)));
                s5_pb = put(s5_pb, s5_ax, sat_c(s5_pb1 + (r4_ptnb >>> FRAC_BITS)));
                s5_va = put(s5_va, s5_ax, r4_va);
                s5_vb = put(s5_vb, s5_ax, r4_vb);
            end
            acr_pkg::MODE_BOUNCE_A: begin
                s5_pa = put(s5_pa, s5_ax, sat_c(s5_pra));
                s5_va = put(s5_va, s5_ax, sat_c(-s5_a0));
            end
            acr_pkg::MODE_BOUNCE_B: begin
                s5_pb = put(s5_pb, s5_ax, sat_c(s5_prb));
                s5_vb = put(s5_vb, s5_ax, sat_c(-s5_b0));
            end
            acr_pkg::MODE_PASS: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+5]) begin
            o_hit         <= s5_ctx[O_HT];
            o_hit_axis    <= s5_ax;
            o_impact_time <= s5_ctx[O_AX-1:O_TM];
            o_new_pos_a   <= s5_pa;
            o_new_vel_a   <= s5_va;
            o_new_pos_b   <= s5_pb;
            o_new_vel_b   <= s5_vb;
        end
    end

endmodule

// File: hdl/aabb_pair_collision_resolve.sv
// Top level of the box pair collision resolver: lanes, merge, response and flow control.
//
// Each input word carries two axis-aligned boxes (centre, half-extent and
// velocity as packed signed fixed-point vectors, plus masses). The input
// channel is i_valid with o_stall; the output channel is o_valid with i_stall.
// A word is taken at a rising edge with valid high and stall low.
// Three axis lanes test overlap and compute the penetration time through a
// pipelined divider, a merging stage picks the response axis, and a response
// pipeline backs the boxes off, exchanges velocity by mass through a
// pair of pipelined dividers and advances them again, or reflects one box.
// One word is accepted per cycle while o_stall is low. The lane and response
// dividers produce one quotient bit per pipeline stage.
// Every stage holds its word until the next stage has room, so bubbles close
// up and new words are accepted while a finished result waits on i_stall.
// Reset clears all valid flags; the pipeline is empty after reset.
module aabb_pair_collision_resolve #(
    parameter int COMP_WIDTH = acr_pkg::DEF_COMP_WIDTH,
    parameter int FRAC_BITS  = acr_pkg::DEF_FRAC_BITS,
    parameter int MASS_WIDTH = acr_pkg::DEF_MASS_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [3*COMP_WIDTH-1:0]      i_pos_a,
    input  logic [3*COMP_WIDTH-1:0]      i_half_a,
    input  logic [3*COMP_WIDTH-1:0]      i_vel_a,
    input  logic [MASS_WIDTH-1:0]        i_mass_a,
    input  logic [3*COMP_WIDTH-1:0]      i_pos_b,
    input  logic [3*COMP_WIDTH-1:0]      i_half_b,
    input  logic [3*COMP_WIDTH-1:0]      i_vel_b,
    input  logic [MASS_WIDTH-1:0]        i_mass_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [1:0]                   o_hit_axis,
    output logic [acr_pkg::TIME_W-1:0]   o_impact_time,
    output logic [3*COMP_WIDTH-1:0]      o_new_pos_a,
    output logic [3*COMP_WIDTH-1:0]      o_new_vel_a,
    output logic [3*COMP_WIDTH-1:0]      o_new_pos_b,
    output logic [3*COMP_WIDTH-1:0]      o_new_vel_b
);

    localparam int CW     = COMP_WIDTH;
    localparam int MW     = MASS_WIDTH;
    localparam int TW     = acr_pkg::TIME_W;
    localparam int VW     = 3 * CW;
    localparam int LN     = TW + 2;
    localparam int RS     = CW + 7;
    localparam int NS     = LN + 1 + RS;
    localparam int ITEM_W = 4 * VW + 2 * MW;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Box data that the response needs, delayed alongside the lanes.
    logic [ITEM_W-1:0] r_item [0:LN-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_item[0] <= {i_mass_b, i_mass_a, i_vel_b, i_pos_b, i_vel_a, i_pos_a};
        end
        for (int k = 1; k < LN; k++) begin
            if (en[k]) begin
                r_item[k] <= r_item[k-1];
            end
        end
    end

    logic [2:0]         ln_overlap;
    logic [2:0]         ln_moving;
    logic [2:0][TW-1:0] ln_time;

    for (genvar a = 0; a < 3; a++) begin : g_lane
        acr_lane #(
            .COMP_WIDTH (CW),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (en[LN-1:0]),
            .i_pos_a   (i_pos_a[a*CW +: CW]),
            .i_half_a  (i_half_a[a*CW +: CW]),
            .i_vel_a   (i_vel_a[a*CW +: CW]),
            .i_pos_b   (i_pos_b[a*CW +: CW]),
            .i_half_b  (i_half_b[a*CW +: CW]),
            .i_vel_b   (i_vel_b[a*CW +: CW]),
            .o_overlap (ln_overlap[a]),
            .o_moving  (ln_moving[a]),
            .o_time    (ln_time[a])
        );
    end

    logic              mg_hit;
    logic [1:0]        mg_axis;
    logic [TW-1:0]     mg_time;
    logic [ITEM_W-1:0] mg_item;

    acr_merge #(
        .ITEM_W (ITEM_W)
    ) u_merge (
        .i_clk     (i_clk),
        .i_en      (en[LN]),
        .i_overlap (ln_overlap),
        .i_moving  (ln_moving),
        .i_time    (ln_time),
        .i_item    (r_item[LN-1]),
        .o_hit     (mg_hit),
        .o_axis    (mg_axis),
        .o_time    (mg_time),
        .o_item    (mg_item)
    );

    acr_resp #(
        .COMP_WIDTH (CW),
        .FRAC_BITS  (FRAC_BITS),
        .MASS_WIDTH (MW)
    ) u_resp (
        .i_clk         (i_clk),
        .i_en          (en[NS-1:LN+1]),
        .i_hit         (mg_hit),
        .i_axis        (mg_axis),
        .i_time        (mg_time),
        .i_pos_a       (mg_item[VW-1:0]),
        .i_vel_a       (mg_item[2*VW-1:VW]),
        .i_pos_b       (mg_item[3*VW-1:2*VW]),
        .i_vel_b       (mg_item[4*VW-1:3*VW]),
        .i_mass_a      (mg_item[4*VW+MW-1:4*VW]),
        .i_mass_b      (mg_item[ITEM_W-1:4*VW+MW]),
        .o_hit         (o_hit),
        .o_hit_axis    (o_hit_axis),
        .o_impact_time (o_impact_time),
        .o_new_pos_a   (o_new_pos_a),
        .o_new_vel_a   (o_new_vel_a),
        .o_new_pos_b   (o_new_pos_b),
        .o_new_vel_b   (o_new_vel_b)
    );

endmodule

// File: hdl/acr_chk.sv
// Port-level checker for the box pair collision resolver, with its bind.
module acr_chk #(
    parameter int COMP_WIDTH = acr_pkg::DEF_COMP_WIDTH
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_hit,
    input logic [1:0]                 o_hit_axis,
    input logic [acr_pkg::TIME_W-1:0] o_impact_time,
    input logic [3*COMP_WIDTH-1:0]    o_new_pos_a
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output word present straight after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_pos_a) && $stable(o_impact_time))
        else $error("Stalled output word changed or vanished.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_hit_axis == acr_pkg::AXIS_X) && (o_impact_time == '0))
        else $error("Axis or time reported without an overlap.");

    a_axis_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_hit_axis != acr_pkg::AXIS_X) |-> o_hit)
        else $error("Response axis chosen without an overlap.");

endmodule

bind aabb_pair_collision_resolve acr_chk #(
    .COMP_WIDTH (COMP_WIDTH)
) u_acr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_hit         (o_hit),
    .o_hit_axis    (o_hit_axis),
    .o_impact_time (o_impact_time),
    .o_new_pos_a   (o_new_pos_a)
);

// File: sim/testbench.sv
// Self-checking testbench for the box pair collision resolver with random stimulus and stalls.
module testbench;

    localparam int CW = acr_pkg::DEF_COMP_WIDTH;
    localparam int FB = acr_pkg::DEF_FRAC_BITS;
    localparam int MW = acr_pkg::DEF_MASS_WIDTH;
    localparam int VW = 3 * CW;
    localparam int LATENCY = CW + 26;
    localparam int N_RANDOM = 1450;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    typedef struct packed {
        logic [VW-1:0] pos_a;
        logic [VW-1:0] half_a;
        logic [VW-1:0] vel_a;
        logic [MW-1:0] mass_a;
        logic [VW-1:0] pos_b;
        logic [VW-1:0] half_b;
        logic [VW-1:0] vel_b;
        logic [MW-1:0] mass_b;
    } t_pair;

    typedef struct packed {
        logic          hit;
        logic [1:0]    axis;
        logic [15:0]   itime;
        logic [VW-1:0] pos_a;
        logic [VW-1:0] vel_a;
        logic [VW-1:0] pos_b;
        logic [VW-1:0] vel_b;
    } t_response;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_hit;
    logic [1:0] o_hit_axis;
    logic [15:0] o_impact_time;
    logic [VW-1:0] o_new_pos_a, o_new_vel_a, o_new_pos_b, o_new_vel_b;
    t_pair cur = '0;

    t_pair pending_pairs[$];
    t_response awaited_responses[$];
    int fail_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit stimulus_done = 1'b0;

    aabb_pair_collision_resolve uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_a(cur.pos_a), .i_half_a(cur.half_a), .i_vel_a(cur.vel_a),
        .i_mass_a(cur.mass_a), .i_pos_b(cur.pos_b), .i_half_b(cur.half_b),
        .i_vel_b(cur.vel_b), .i_mass_b(cur.mass_b), .o_valid(o_valid),
        .i_stall(i_stall), .o_hit(o_hit), .o_hit_axis(o_hit_axis),
        .o_impact_time(o_impact_time), .o_new_pos_a(o_new_pos_a),
        .o_new_vel_a(o_new_vel_a), .o_new_pos_b(o_new_pos_b), .o_new_vel_b(o_new_vel_b)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint comp(logic [VW-1:0] v, int i);
        logic signed [CW-1:0] c;
        c = v[i*CW +: CW];
        return longint'(c);
    endfunction

    function automatic longint clamp(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic logic [VW-1:0] pack_vec(longint v[3]);
        logic [VW-1:0] r;
        longint s;
        for (int i = 0; i < 3; i++) begin
            s = clamp(v[i]);
            r[i*CW +: CW] = s[CW-1:0];
        end
        return r;
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
        return q;
    endfunction

    function automatic t_response resolve_pair(t_pair p);
        longint pa[3], ha[3], va[3], pb[3], hb[3], vb[3];
        longint amin[3], amax[3], bmin[3], bmax[3];
        longint t, ti, vr, depth, ma, mb, a0, b0, na, nb;
        bit overlap, found;
        int ax;
        t_response r;
        overlap = 1'b1;
        found = 1'b0;
        t = 0;
        ax = 0;
        ma = longint'(p.mass_a);
        mb = longint'(p.mass_b);
        for (int i = 0; i < 3; i++) begin
            pa[i] = comp(p.pos_a, i); ha[i] = comp(p.half_a, i); va[i] = comp(p.vel_a, i);
            pb[i] = comp(p.pos_b, i); hb[i] = comp(p.half_b, i); vb[i] = comp(p.vel_b, i);
            amin[i] = pa[i] - ha[i]; amax[i] = pa[i] + ha[i];
            bmin[i] = pb[i] - hb[i]; bmax[i] = pb[i] + hb[i];
            if (amin[i] > bmax[i] || bmin[i] > amax[i]) overlap = 1'b0;
        end
        if (overlap) begin
            for (int i = 0; i < 3; i++) begin
                vr = vb[i] - va[i];
                if (vr != 0) begin
                    depth = vr < 0 ? amax[i] - bmin[i] : bmax[i] - amin[i];
                    if (depth < 0) depth = -depth;
                    if (vr < 0) vr = -vr;
                    ti = (depth <<< FB) / vr;
                    if (ti > 16'hFFFF) ti = 16'hFFFF;
                    if (!found || ti < t) begin
                        t = ti;
                        ax = i;
                        found = 1'b1;
                    end
                end
            end
            if (ma != 0 && mb != 0) begin
                a0 = va[ax];
                b0 = vb[ax];
                pa[ax] -= (a0 * t) >>> FB;
                pb[ax] -= (b0 * t) >>> FB;
                na = fdiv((ma - mb) * a0 + 2 * mb * b0, ma + mb);
                nb = fdiv((mb - ma) * b0 + 2 * ma * a0, ma + mb);
                va[ax] = clamp(na);
                vb[ax] = clamp(nb);
                pa[ax] += (va[ax] * t) >>> FB;
                pb[ax] += (vb[ax] * t) >>> FB;
            end else if (ma == 0 && mb != 0) begin
                pb[ax] -= (2 * vb[ax] * t) >>> FB;
                vb[ax] = clamp(-vb[ax]);
            end else if (ma != 0 && mb == 0) begin
                pa[ax] -= (2 * va[ax] * t) >>> FB;
                va[ax] = clamp(-va[ax]);
            end
        end
        r.hit = overlap;
        r.axis = ax[1:0];
        r.itime = t[15:0];
        r.pos_a = pack_vec(pa);
        r.vel_a = pack_vec(va);
        r.pos_b = pack_vec(pb);
        r.vel_b = pack_vec(vb);
        return r;
    endfunction

    function automatic logic [VW-1:0] rand_vec(int lo, int hi);
        logic [VW-1:0] r;
        int c;
        for (int i = 0; i < 3; i++) begin
            c = $urandom_range(hi - lo) + lo;
            r[i*CW +: CW] = c[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] full_vec();
        return VW'({$urandom, $urandom});
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int kind;
        kind = $urandom_range(9);
        p.mass_a = ($urandom_range(5) == 0) ? '0 : MW'($urandom);
        p.mass_b = ($urandom_range(5) == 0) ? '0 : MW'($urandom);
        if (kind < 2) begin
            p.pos_a = full_vec(); p.half_a = full_vec(); p.vel_a = full_vec();
            p.pos_b = full_vec(); p.half_b = full_vec(); p.vel_b = full_vec();
        end else begin
            // Nearby boxes with moderate sizes so that most of them overlap.
            p.pos_a = rand_vec(-2048, 2048);
            p.pos_b = p.pos_a + rand_vec(-512, 512);
            p.half_a = rand_vec(0, 1024);
            p.half_b = rand_vec(0, 1024);
            p.vel_a = (kind == 9) ? full_vec() : rand_vec(-1024, 1024);
            p.vel_b = (kind == 8) ? p.vel_a : rand_vec(-1024, 1024);
            if (kind == 7) p.mass_b = p.mass_a;
        end
        return p;
    endfunction

    initial begin
        t_pair p;
        logic [VW-1:0] vmax, vmin;
        for (int i = 0; i < 3; i++) begin
            vmax[i*CW +: CW] = CMAX[CW-1:0];
            vmin[i*CW +: CW] = CMIN[CW-1:0];
        end
        p = '0;
        pending_pairs.push_back(p);
        p.half_a = {3{16'h0100}}; p.half_b = {3{16'h0100}};
        p.pos_b = {3{16'h0200}};
        p.vel_a = {3{16'h0080}}; p.mass_a = 16'd1; p.mass_b = 16'd1;
        pending_pairs.push_back(p);
        p.pos_b = {16'h0200, 16'h0080, 16'h0100};
        p.vel_b = {16'hFF80, 16'h0040, 16'h0000};
        pending_pairs.push_back(p);
        p.mass_a = '0;
        pending_pairs.push_back(p);
        p.mass_a = 16'd3; p.mass_b = '0;
        pending_pairs.push_back(p);
        p.mass_b = '0; p.mass_a = '0;
        pending_pairs.push_back(p);
        p.mass_a = '1; p.mass_b = '1;
        p.vel_a = vmax; p.vel_b = vmin;
        pending_pairs.push_back(p);
        p.mass_a = '1; p.mass_b = 16'd1;
        pending_pairs.push_back(p);
        p.mass_a = '0;
        pending_pairs.push_back(p);
        p.vel_b = p.vel_a;
        pending_pairs.push_back(p);
        p.pos_a = vmax; p.pos_b = vmin; p.half_a = vmax; p.half_b = vmax;
        p.vel_a = vmin; p.vel_b = vmax;
        pending_pairs.push_back(p);
        p.half_a = vmin; p.half_b = vmin;
        pending_pairs.push_back(p);
        p.pos_a = '1; p.half_a = '1; p.vel_a = '1; p.mass_a = '1;
        p.pos_b = '1; p.half_b = '1; p.vel_b = '0; p.mass_b = '1;
        pending_pairs.push_back(p);
        p.pos_a = {3{16'h0000}}; p.pos_b = {3{16'h0500}};
        p.half_a = {3{16'h0100}}; p.half_b = {3{16'h0100}};
        pending_pairs.push_back(p);
        p.pos_b = {3{16'h0200}}; p.vel_a = {16'h0001, 16'h0001, 16'h0001}; p.vel_b = '0;
        pending_pairs.push_back(p);
        for (int n = 0; n < N_RANDOM; n++) pending_pairs.push_back(random_pair());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stimulus_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                awaited_responses.push_back(resolve_pair(cur));
                void'(pending_pairs.pop_front());
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0 || pending_pairs.size() == 0 || (i_valid && !o_stall
                        && pending_pairs.size() == 0)) begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else if (i_valid && !o_stall && send_gap == 0) begin
                    // The word just taken is replaced, or a gap is opened first.
                    if ($urandom_range(3) == 0) begin
                        i_valid <= 1'b0;
                        send_gap <= $urandom_range(3);
                    end else begin
                        i_valid <= 1'b1;
                        cur <= pending_pairs[0];
                    end
                end else begin
                    i_valid <= 1'b1;
                    cur <= pending_pairs[0];
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (awaited_responses.size() == 0) begin
                    $display("%0t: unexpected word, hit %0b", $time, o_hit);
                    fail_count++;
                end else begin
                    t_response e;
                    e = awaited_responses.pop_front();
                    if (e.hit !== o_hit) begin
                        $display("%0t hit: expected %0b actual %0b", $time, e.hit, o_hit);
                        fail_count++;
                    end
                    if (e.axis !== o_hit_axis) begin
                        $display("%0t axis: expected %0d actual %0d", $time, e.axis, o_hit_axis);
                        fail_count++;
                    end
                    if (e.itime !== o_impact_time) begin
                        $display("%0t time: expected %h actual %h", $time, e.itime,
                                 o_impact_time);
                        fail_count++;
                    end
                    if (e.pos_a !== o_new_pos_a) begin
                        $display("%0t pos_a: expected %h actual %h", $time, e.pos_a,
                                 o_new_pos_a);
                        fail_count++;
                    end
                    if (e.vel_a !== o_new_vel_a) begin
                        $display("%0t vel_a: expected %h actual %h", $time, e.vel_a,
                                 o_new_vel_a);
                        fail_count++;
                    end
                    if (e.pos_b !== o_new_pos_b) begin
                        $display("%0t pos_b: expected %h actual %h", $time, e.pos_b,
                                 o_new_pos_b);
                        fail_count++;
                    end
                    if (e.vel_b !== o_new_vel_b) begin
                        $display("%0t vel_b: expected %h actual %h", $time, e.vel_b,
                                 o_new_vel_b);
                        fail_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall && $urandom_range(2) == 0) begin
                recv_gap <= $urandom_range(3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (pending_pairs.size() != 0 || i_valid || awaited_responses.size() != 0) begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0 && awaited_responses.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/acr_pkg.sv
hdl/acr_div.sv
hdl/acr_lane.sv
hdl/acr_merge.sv
hdl/acr_resp.sv
hdl/aabb_pair_collision_resolve.sv
hdl/acr_chk.sv
sim/testbench.sv
